/* hw/rtl/gts_pkg.sv */
// grouped topological sort: shared types and constants
// no dependencies; imported by grouped_topological_sort
package gts_pkg;

  localparam int GROUP_SLOTS = 128;
  localparam int ITEM_SLOTS  = 64;

  localparam logic [1:0] KIND_SET  = 2'd0;
  localparam logic [1:0] KIND_EDGE = 2'd1;
  localparam logic [1:0] KIND_RUN  = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CLR, ST_AS0, ST_AS1,
    ST_E0, ST_E1, ST_E2, ST_E3,
    ST_GS0, ST_GS1, ST_GQ0, ST_GQ1,
    ST_IG0, ST_IG1, ST_IS0, ST_IS1, ST_IQ0, ST_IQ1,
    ST_CHK, ST_O0, ST_O1, ST_O2, ST_FAIL
  } state_t;

  typedef enum logic [1:0] {
    MODE_DEG, MODE_GRP, MODE_ITM
  } mode_t;

endpackage

/* hw/rtl/grouped_topological_sort.sv */
// grouped topological sort: set-group and add-edge requests are taken in idle.
// a run request clears the degree tables, assigns groups, counts degrees, then
// walks groups and items; every dequeued node rescans all stored edges, and the
// results are then shown one at a time.
// reset (synchronous, rst_n low) clears the edge count and control; tables persist.
module grouped_topological_sort
  import gts_pkg::*;
#(
  parameter int MAX_ITEMS  = 64,
  parameter int MAX_GROUPS = 64,
  parameter int MAX_EDGES  = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_kind,
  input  logic [5:0]        in_item_id,
  input  logic signed [6:0] in_group_id,
  input  logic [5:0]        in_prior_item,
  input  logic [6:0]        in_item_count,
  input  logic [6:0]        in_group_count,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [5:0]        out_ordered_item,
  output logic              out_status,
  output logic              out_last
);

  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int DW  = ECW;

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;
  logic [7:0]     s_r, s_nxt;
  logic [ECW-1:0] e_r, e_nxt;
  logic [ECW-1:0] edge_cnt_r, edge_cnt_nxt;
  logic [6:0] n_r, n_nxt;
  logic [7:0] next_r, next_nxt, total_r, total_nxt, cnt_r, cnt_nxt, gi_r, gi_nxt;
  logic [6:0] k_r, k_nxt;
  logic [5:0] oi_r, oi_nxt;
  logic [7:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [6:0] cur_r, cur_nxt, grp_r, grp_nxt, tgt_r, tgt_nxt;
  logic [5:0] p_r, p_nxt, c_r, c_nxt;
  logic       tsel_r, tsel_nxt;
  logic [GROUP_SLOTS-1:0] present_r, present_nxt, gdone_r, gdone_nxt, pres_init;
  logic [ITEM_SLOTS-1:0]  idone_r, idone_nxt;
  logic       out_valid_r, out_valid_nxt, out_status_r, out_status_nxt;
  logic       out_last_r, out_last_nxt;
  logic [5:0] out_item_r, out_item_nxt;

  // ram ports
  logic           igt_we;   logic [5:0] igt_waddr, igt_raddr; logic [6:0] igt_wdata, igt_rdata;
  logic           edg_we;   logic [EAW-1:0] edg_waddr, edg_raddr;
  logic [11:0]    edg_wdata, edg_rdata;
  logic           ig_we;    logic [5:0] ig_waddr, iga_raddr, igb_raddr;
  logic [6:0]     ig_wdata, iga_rdata, igb_rdata;
  logic           gdeg_we;  logic [6:0] gdeg_waddr, gdeg_raddr;
  logic [DW-1:0]  gdeg_wdata, gdeg_rdata;
  logic           ideg_we;  logic [5:0] ideg_waddr, ideg_raddr;
  logic [DW-1:0]  ideg_wdata, ideg_rdata;
  logic           que_we;   logic [6:0] que_waddr, que_raddr, que_wdata, que_rdata;
  logic           gord_we;  logic [6:0] gord_waddr, gord_raddr, gord_wdata, gord_rdata;
  logic           obuf_we;  logic [5:0] obuf_waddr, obuf_raddr, obuf_wdata, obuf_rdata;

  gts_ram #(.WIDTH(7), .DEPTH(ITEM_SLOTS)) u_igt (
    .clk, .we(igt_we), .waddr(igt_waddr), .wdata(igt_wdata),
    .raddr(igt_raddr), .rdata(igt_rdata));
  gts_ram #(.WIDTH(12), .DEPTH(MAX_EDGES)) u_edge (
    .clk, .we(edg_we), .waddr(edg_waddr), .wdata(edg_wdata),
    .raddr(edg_raddr), .rdata(edg_rdata));
  gts_ram #(.WIDTH(7), .DEPTH(ITEM_SLOTS)) u_iga (
    .clk, .we(ig_we), .waddr(ig_waddr), .wdata(ig_wdata),
    .raddr(iga_raddr), .rdata(iga_rdata));
  gts_ram #(.WIDTH(7), .DEPTH(ITEM_SLOTS)) u_igb (
    .clk, .we(ig_we), .waddr(ig_waddr), .wdata(ig_wdata),
    .raddr(igb_raddr), .rdata(igb_rdata));
  gts_ram #(.WIDTH(DW), .DEPTH(GROUP_SLOTS)) u_gdeg (
    .clk, .we(gdeg_we), .waddr(gdeg_waddr), .wdata(gdeg_wdata),
    .raddr(gdeg_raddr), .rdata(gdeg_rdata));
  gts_ram #(.WIDTH(DW), .DEPTH(ITEM_SLOTS)) u_ideg (
    .clk, .we(ideg_we), .waddr(ideg_waddr), .wdata(ideg_wdata),
    .raddr(ideg_raddr), .rdata(ideg_rdata));
  gts_ram #(.WIDTH(7), .DEPTH(GROUP_SLOTS)) u_que (
    .clk, .we(que_we), .waddr(que_waddr), .wdata(que_wdata),
    .raddr(que_raddr), .rdata(que_rdata));
  gts_ram #(.WIDTH(7), .DEPTH(GROUP_SLOTS)) u_gord (
    .clk, .we(gord_we), .waddr(gord_waddr), .wdata(gord_wdata),
    .raddr(gord_raddr), .rdata(gord_rdata));
  gts_ram #(.WIDTH(6), .DEPTH(ITEM_SLOTS)) u_obuf (
    .clk, .we(obuf_we), .waddr(obuf_waddr), .wdata(obuf_wdata),
    .raddr(obuf_raddr), .rdata(obuf_rdata));

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_ordered_item = out_item_r;
  assign out_status       = out_status_r;
  assign out_last         = out_last_r;

  logic [6:0]    n_sat, m_sat, g_new;
  logic          edge_ok;
  logic [DW-1:0] deg_rd, deg_dec;

  always_comb begin
    n_sat = (in_item_count > 7'(MAX_ITEMS)) ? 7'(MAX_ITEMS) : in_item_count;
    m_sat = (in_group_count > 7'(MAX_GROUPS)) ? 7'(MAX_GROUPS) : in_group_count;
    for (int j = 0; j < GROUP_SLOTS; j++) begin
      pres_init[j] = (8'(j) < {1'b0, m_sat});
    end
  end

  always_comb begin
    state_nxt = state_r;   mode_nxt = mode_r;     s_nxt = s_r;       e_nxt = e_r;
    edge_cnt_nxt = edge_cnt_r; n_nxt = n_r;       next_nxt = next_r;
    total_nxt = total_r;   cnt_nxt = cnt_r;       gi_nxt = gi_r;     k_nxt = k_r;
    oi_nxt = oi_r;         head_nxt = head_r;     tail_nxt = tail_r; cur_nxt = cur_r;
    grp_nxt = grp_r;       tgt_nxt = tgt_r;       p_nxt = p_r;       c_nxt = c_r;
    tsel_nxt = tsel_r;     present_nxt = present_r; gdone_nxt = gdone_r;
    idone_nxt = idone_r;   out_valid_nxt = out_valid_r; out_status_nxt = out_status_r;
    out_last_nxt = out_last_r; out_item_nxt = out_item_r;

    igt_we = 1'b0;  igt_waddr = in_item_id; igt_wdata = $unsigned(in_group_id);
    igt_raddr = s_r[5:0];
    edg_we = 1'b0;  edg_waddr = edge_cnt_r[EAW-1:0];
    edg_wdata = {in_prior_item, in_item_id};  edg_raddr = e_r[EAW-1:0];
    ig_we = 1'b0;   ig_waddr = s_r[5:0];  ig_wdata = '0;
    iga_raddr = s_r[5:0];  igb_raddr = c_r;
    gdeg_we = 1'b0; gdeg_waddr = tgt_r; gdeg_wdata = '0; gdeg_raddr = s_r[6:0];
    ideg_we = 1'b0; ideg_waddr = tgt_r[5:0]; ideg_wdata = '0; ideg_raddr = s_r[5:0];
    que_we = 1'b0;  que_waddr = tail_r[6:0]; que_wdata = tgt_r; que_raddr = head_r[6:0];
    gord_we = 1'b0; gord_waddr = cnt_r[6:0]; gord_wdata = que_rdata; gord_raddr = gi_r[6:0];
    obuf_we = 1'b0; obuf_waddr = k_r[5:0]; obuf_wdata = que_rdata[5:0];
    obuf_raddr = oi_r;

    g_new   = igt_rdata[6] ? next_r[6:0] : {1'b0, igt_rdata[5:0]};
    edge_ok = ({1'b0, p_r} < n_r) && ({1'b0, c_r} < n_r);
    deg_rd  = tsel_r ? gdeg_rdata : ideg_rdata;
    deg_dec = (deg_rd != '0) ? deg_rd - DW'(1) : '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_kind)
            KIND_SET: igt_we = 1'b1;
            KIND_EDGE: begin
              if (edge_cnt_r < ECW'(MAX_EDGES)) begin
                edg_we = 1'b1;
                edge_cnt_nxt = edge_cnt_r + ECW'(1);
              end
            end
            KIND_RUN: begin
              n_nxt = n_sat;
              if (n_sat == 7'd0) begin
                state_nxt = ST_FAIL;
              end else begin
                present_nxt = pres_init;
                total_nxt = {1'b0, m_sat};
                next_nxt = {1'b0, m_sat};
                gdone_nxt = '0;
                idone_nxt = '0;
                s_nxt = 8'd0;
                state_nxt = ST_CLR;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CLR: begin
        gdeg_we = 1'b1; gdeg_waddr = s_r[6:0];
        ideg_we = (s_r < 8'(ITEM_SLOTS)); ideg_waddr = s_r[5:0];
        s_nxt = s_r + 8'd1;
        if (s_r == 8'(GROUP_SLOTS - 1)) begin
          s_nxt = 8'd0;
          state_nxt = ST_AS0;
        end
      end
      ST_AS0: begin
        if (s_r == {1'b0, n_r}) begin
          e_nxt = '0;
          mode_nxt = MODE_DEG;
          state_nxt = ST_E0;
        end else begin
          state_nxt = ST_AS1;
        end
      end
      ST_AS1: begin
        // negative group: fresh id in item order
        ig_we = 1'b1; ig_wdata = g_new;
        if (igt_rdata[6]) next_nxt = next_r + 8'd1;
        if (!present_r[g_new]) begin
          present_nxt[g_new] = 1'b1;
          total_nxt = total_r + 8'd1;
        end
        s_nxt = s_r + 8'd1;
        state_nxt = ST_AS0;
      end
      ST_E0: begin
        if (e_r == edge_cnt_r) begin
          case (mode_r)
            MODE_DEG: begin
              s_nxt = 8'd0; head_nxt = 8'd0; tail_nxt = 8'd0; cnt_nxt = 8'd0;
              state_nxt = ST_GS0;
            end
            MODE_GRP: state_nxt = ST_GQ0;
            default:  state_nxt = ST_IQ0;
          endcase
        end else begin
          state_nxt = ST_E1;
        end
      end
      ST_E1: begin
        p_nxt = edg_rdata[11:6];
        c_nxt = edg_rdata[5:0];
        iga_raddr = edg_rdata[11:6];
        igb_raddr = edg_rdata[5:0];
        state_nxt = ST_E2;
      end
      ST_E2: begin
        gdeg_raddr = igb_rdata;
        ideg_raddr = c_r;
        tgt_nxt = igb_rdata;
        tsel_nxt = 1'b1;
        e_nxt = e_r + ECW'(1);
        state_nxt = ST_E0;
        case (mode_r)
          MODE_DEG: begin
            if (edge_ok) begin
              if (iga_rdata == igb_rdata) begin
                tgt_nxt = {1'b0, c_r};
                tsel_nxt = 1'b0;
              end
              e_nxt = e_r;
              state_nxt = ST_E3;
            end
          end
          MODE_GRP: begin
            if (edge_ok && iga_rdata == cur_r && igb_rdata != cur_r) begin
              e_nxt = e_r;
              state_nxt = ST_E3;
            end
          end
          default: begin
            if ({1'b0, p_r} == cur_r && {1'b0, c_r} < n_r && iga_rdata == igb_rdata) begin
              tgt_nxt = {1'b0, c_r};
              tsel_nxt = 1'b0;
              e_nxt = e_r;
              state_nxt = ST_E3;
            end
          end
        endcase
      end
      ST_E3: begin
        e_nxt = e_r + ECW'(1);
        state_nxt = ST_E0;
        if (mode_r == MODE_DEG) begin
          gdeg_we = tsel_r; ideg_we = !tsel_r;
          gdeg_wdata = deg_rd + DW'(1); ideg_wdata = deg_rd + DW'(1);
        end else begin
          gdeg_we = tsel_r; ideg_we = !tsel_r;
          gdeg_wdata = deg_dec; ideg_wdata = deg_dec;
          if (deg_dec == '0) begin
            if (tsel_r && !gdone_r[tgt_r]) begin
              gdone_nxt[tgt_r] = 1'b1;
              que_we = 1'b1;
              tail_nxt = tail_r + 8'd1;
            end else if (!tsel_r && !idone_r[tgt_r[5:0]]) begin
              idone_nxt[tgt_r[5:0]] = 1'b1;
              que_we = 1'b1;
              tail_nxt = tail_r + 8'd1;
            end
          end
        end
      end
      ST_GS0: begin
        if (s_r[7]) begin
          if (cnt_r == total_r) begin
            gi_nxt = 8'd0; k_nxt = 7'd0;
            state_nxt = ST_IG0;
          end else begin
            state_nxt = ST_FAIL;
          end
        end else if (present_r[s_r[6:0]] && !gdone_r[s_r[6:0]]) begin
          state_nxt = ST_GS1;
        end else begin
          s_nxt = s_r + 8'd1;
        end
      end
      ST_GS1: begin
        if (gdeg_rdata == '0) begin
          gdone_nxt[s_r[6:0]] = 1'b1;
          que_we = 1'b1; que_wdata = s_r[6:0];
          tail_nxt = tail_r + 8'd1;
          state_nxt = ST_GQ0;
        end else begin
          s_nxt = s_r + 8'd1;
          state_nxt = ST_GS0;
        end
      end
      ST_GQ0: begin
        if (head_r == tail_r) begin
          s_nxt = s_r + 8'd1;
          state_nxt = ST_GS0;
        end else begin
          state_nxt = ST_GQ1;
        end
      end
      ST_GQ1: begin
        cur_nxt = que_rdata;
        head_nxt = head_r + 8'd1;
        gord_we = 1'b1;
        cnt_nxt = cnt_r + 8'd1;
        e_nxt = '0;
        mode_nxt = MODE_GRP;
        state_nxt = ST_E0;
      end
      ST_IG0: begin
        if (gi_r == cnt_r) begin
          state_nxt = ST_CHK;
        end else begin
          state_nxt = ST_IG1;
        end
      end
      ST_IG1: begin
        grp_nxt = gord_rdata;
        s_nxt = 8'd0; head_nxt = 8'd0; tail_nxt = 8'd0;
        state_nxt = ST_IS0;
      end
      ST_IS0: begin
        if (s_r == {1'b0, n_r}) begin
          gi_nxt = gi_r + 8'd1;
          state_nxt = ST_IG0;
        end else if (idone_r[s_r[5:0]]) begin
          s_nxt = s_r + 8'd1;
        end else begin
          state_nxt = ST_IS1;
        end
      end
      ST_IS1: begin
        if (iga_rdata == grp_r && ideg_rdata == '0) begin
          idone_nxt[s_r[5:0]] = 1'b1;
          que_we = 1'b1; que_wdata = s_r[6:0];
          tail_nxt = tail_r + 8'd1;
          state_nxt = ST_IQ0;
        end else begin
          s_nxt = s_r + 8'd1;
          state_nxt = ST_IS0;
        end
      end
      ST_IQ0: begin
        if (head_r == tail_r) begin
          s_nxt = s_r + 8'd1;
          state_nxt = ST_IS0;
        end else begin
          state_nxt = ST_IQ1;
        end
      end
      ST_IQ1: begin
        cur_nxt = que_rdata;
        head_nxt = head_r + 8'd1;
        obuf_we = 1'b1;
        k_nxt = k_r + 7'd1;
        e_nxt = '0;
        mode_nxt = MODE_ITM;
        state_nxt = ST_E0;
      end
      ST_CHK: begin
        oi_nxt = 6'd0;
        state_nxt = (k_r == n_r) ? ST_O0 : ST_FAIL;
      end
      ST_O0: state_nxt = ST_O1;
      ST_O1: begin
        out_valid_nxt = 1'b1;
        out_item_nxt = obuf_rdata;
        out_status_nxt = 1'b0;
        out_last_nxt = ({1'b0, oi_r} == k_r - 7'd1);
        state_nxt = ST_O2;
      end
      ST_O2: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            oi_nxt = oi_r + 6'd1;
            state_nxt = ST_O0;
          end
        end
      end
      ST_FAIL: begin
        out_valid_nxt = 1'b1;
        out_item_nxt = 6'd0;
        out_status_nxt = 1'b1;
        out_last_nxt = 1'b1;
        state_nxt = ST_O2;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r <= MODE_DEG;
      edge_cnt_r <= '0;
      out_valid_r <= 1'b0;
      head_r <= 8'd0;
      tail_r <= 8'd0;
      k_r <= 7'd0;
      n_r <= 7'd0;
    end else begin
      state_r <= state_nxt;
      mode_r <= mode_nxt;
      edge_cnt_r <= edge_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      k_r <= k_nxt;
      n_r <= n_nxt;
    end
    s_r <= s_nxt;          e_r <= e_nxt;
    next_r <= next_nxt;    total_r <= total_nxt;  cnt_r <= cnt_nxt;
    gi_r <= gi_nxt;        oi_r <= oi_nxt;        cur_r <= cur_nxt;
    grp_r <= grp_nxt;      tgt_r <= tgt_nxt;      p_r <= p_nxt;
    c_r <= c_nxt;          tsel_r <= tsel_nxt;    present_r <= present_nxt;
    gdone_r <= gdone_nxt;  idone_r <= idone_nxt;  out_status_r <= out_status_nxt;
    out_last_r <= out_last_nxt; out_item_r <= out_item_nxt;
  end

  // a request shown on the output is held in its own wait state
  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == ST_O2)
    else $error("output valid outside wait state");

  // the final request returns the block to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r && !out_stall |=> state_r == ST_IDLE)
    else $error("block not idle after last request");

  // the sweep queue never holds more than its depth
  a_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_r - head_r) <= 8'(GROUP_SLOTS))
    else $error("sweep queue overrun");

endmodule

/* hw/rtl/gts_ram.sv */
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module gts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
